/* hdl/utf8_decode_glyph_slot_assign_top_assert.svh */
// assertion macros shared by the checker of the glyph slot decoder
// depends on nothing; every macro expects clk and arst_n in scope
`ifndef UTF8_DECODE_GLYPH_SLOT_ASSIGN_TOP_ASSERT_SVH
`define UTF8_DECODE_GLYPH_SLOT_ASSIGN_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define UGSA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ugsa check failed");

// next-cycle implication, off during reset
`define UGSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ugsa check failed");

`endif

/* hdl/ugsa_pkg.sv */
// shared types and constants of the utf-8 decoder with glyph slot assignment
// depends on nothing
package ugsa_pkg;

	localparam int CODE_W = 21;
	localparam int POS_W  = 10;
	localparam int SLOT_W = 7;
	localparam int POS_FIELD_MAX = 1023;

	// lead byte classes
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	// one decoded character heading for the glyph cells
	typedef struct packed {
		logic [CODE_W-1:0] code_point;
		logic [POS_W-1:0]  char_position;
	} dec_item_t;

endpackage

/* hdl/ugsa_glyph_cell.sv */
// one glyph table entry: stored code point, valid flag and compare
// depends on ugsa_pkg; cells form a chain through their valid flags
module ugsa_glyph_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       insert,
	input  logic                       prev_valid,
	input  logic [ugsa_pkg::CODE_W-1:0] lookup_code,
	output logic                       valid,
	output logic                       match
);
	import ugsa_pkg::*;

	logic              valid_q;
	logic [CODE_W-1:0] code_q;
	logic              wr_en;

	// the first empty cell after a filled neighbor takes the new code
	assign wr_en = insert & prev_valid & ~valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_q <= lookup_code;
		end
	end

	assign valid = valid_q;
	assign match = valid_q & (code_q == lookup_code);

endmodule

/* hdl/ugsa_decoder.sv */
// byte-serial utf-8 sequence collector with position counter
// depends on ugsa_pkg; feeds one decoded character per cycle at most
module ugsa_decoder #(
	parameter int POS_CAP = 1023
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic [7:0]            text_byte,
	input  logic                  first_of_text,
	input  logic                  advance,
	output logic                  valid_s1,
	output ugsa_pkg::dec_item_t   item_s1
);
	import ugsa_pkg::*;

	logic [CODE_W-1:0] partial_q;
	logic [1:0]        pending_q;
	logic [CODE_W-1:0] last_q;
	logic [POS_W-1:0]  pos_q;
	logic              valid_q;

	logic [CODE_W-1:0] partial_in, last_in, partial_nx, last_nx, cp;
	logic [1:0]        pending_in, pending_nx;
	logic [POS_W-1:0]  pos_in, pos_nx;
	logic              emit;

	// next decoder state for the incoming byte
	always_comb begin
		partial_in = first_of_text ? '0 : partial_q;
		pending_in = first_of_text ? '0 : pending_q;
		last_in    = first_of_text ? '0 : last_q;
		pos_in     = first_of_text ? '0 : pos_q;
		partial_nx = partial_in;
		pending_nx = pending_in;
		last_nx    = last_in;
		cp         = last_in;
		emit       = 1'b0;
		if (pending_in != 2'd0) begin
			partial_nx = {partial_in[CODE_W-7:0], text_byte[5:0]};
			pending_nx = pending_in - 2'd1;
			cp         = partial_nx;
			emit       = (pending_nx == 2'd0);
		end else if ((text_byte & ASCII_MASK) == 8'h00) begin
			cp   = {{(CODE_W-8){1'b0}}, text_byte};
			emit = 1'b1;
		end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
			partial_nx = {{(CODE_W-5){1'b0}}, text_byte[4:0]};
			pending_nx = 2'd1;
		end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
			partial_nx = {{(CODE_W-4){1'b0}}, text_byte[3:0]};
			pending_nx = 2'd2;
		end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
			partial_nx = {{(CODE_W-3){1'b0}}, text_byte[2:0]};
			pending_nx = 2'd3;
		end else begin
			// stray continuation or invalid lead repeats the last character
			emit = 1'b1;
		end
		pos_nx = pos_in;
		if (emit) begin
			last_nx = cp;
			if (pos_in < POS_W'(POS_CAP)) begin
				pos_nx = pos_in + 1'b1;
			end
		end
	end

	// decoder control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= '0;
			last_q    <= '0;
			pos_q     <= '0;
			valid_q   <= 1'b0;
		end else if (in_fire) begin
			partial_q <= partial_nx;
			pending_q <= pending_nx;
			last_q    <= last_nx;
			pos_q     <= pos_nx;
			valid_q   <= emit;
		end else if (advance) begin
			valid_q   <= 1'b0;
		end
	end

	// decoded character register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.code_point    <= cp;
			item_s1.char_position <= pos_in;
		end
	end

	assign valid_s1 = valid_q;

endmodule

/* hdl/utf8_decode_glyph_slot_assign_top.sv */
// Byte-stream UTF-8 decoder with dense glyph slot assignment. One text byte is
// accepted per cycle; output stalls hold the pipeline, and a byte is still
// taken while the decode register is empty. A finished character passes the
// decode register and then the output register. The glyph lookup is a
// combinational compare across a chain of GLYPH_SLOTS cells, one per slot; the
// first empty cell after a filled one takes a new code point, so slots fill in
// order and the table empties only on reset. That compare sets the clock rate.
// depends on ugsa_pkg, ugsa_decoder and ugsa_glyph_cell
module utf8_decode_glyph_slot_assign_top #(
	parameter int GLYPH_SLOTS = 128,
	parameter int MAX_CHARS   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte[7:0]
	input  logic [0:0]  s_tuser,   // first_of_text[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// code_point[20:0], glyph_slot[27:21], new_glyph[28], table_full[29],
	// char_position[39:30]
	output logic [39:0] m_tdata
);
	import ugsa_pkg::*;

	localparam int SW = $clog2(GLYPH_SLOTS);
	localparam int CW = $clog2(GLYPH_SLOTS + 1);
	localparam int PosCap = (MAX_CHARS - 1 < POS_FIELD_MAX) ? MAX_CHARS - 1 : POS_FIELD_MAX;

	logic              advance, in_fire, fire_s2, valid_s1;
	dec_item_t         item_s1;
	logic [GLYPH_SLOTS-1:0] cell_valid, cell_match;
	logic [GLYPH_SLOTS:0]   valid_chain;
	logic [SW-1:0]     hit_idx;
	logic              hit, full, insert;
	logic [CW-1:0]     slots_used_q;
	logic [SW-1:0]     slot;
	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;

	// flow control: the pipeline moves whenever the output register is free
	assign advance  = ~m_tvalid_q | m_tready;
	assign s_tready = ~valid_s1 | advance;
	assign in_fire  = s_tvalid & s_tready;
	assign fire_s2  = valid_s1 & advance;

	ugsa_decoder #(
		.POS_CAP(PosCap)
	) u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.text_byte    (s_tdata),
		.first_of_text(s_tuser[0]),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	// chain of glyph cells, linked by their valid flags
	assign valid_chain[0] = 1'b1;
	for (genvar g = 0; g < GLYPH_SLOTS; g++) begin : g_cell
		ugsa_glyph_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.insert     (insert),
			.prev_valid (valid_chain[g]),
			.lookup_code(item_s1.code_point),
			.valid      (cell_valid[g]),
			.match      (cell_match[g])
		);
		assign valid_chain[g+1] = cell_valid[g];
	end

	// stored codes are unique, so at most one cell matches
	always_comb begin
		hit_idx = '0;
		for (int k = 0; k < GLYPH_SLOTS; k++) begin
			if (cell_match[k]) begin
				hit_idx = hit_idx | SW'(k);
			end
		end
	end

	assign hit    = |cell_match;
	assign full   = (slots_used_q == CW'(GLYPH_SLOTS));
	assign insert = fire_s2 & ~hit & ~full;
	assign slot   = hit ? hit_idx : (full ? '0 : slots_used_q[SW-1:0]);

	// fill count of the glyph table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= '0;
		end else if (insert) begin
			slots_used_q <= slots_used_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			m_tdata_q <= {item_s1.char_position, ~hit & full, ~hit & ~full,
				SLOT_W'({{(32 - SW){1'b0}}, slot}), item_s1.code_point};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* hdl/ugsa_checker.sv */
// port-level checks of the glyph slot decoder, bound to its top level
// depends on utf8_decode_glyph_slot_assign_top_assert.svh
`include "utf8_decode_glyph_slot_assign_top_assert.svh"

module ugsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a stalled request stays and holds its payload
	`UGSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`UGSA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

	// an empty output register never blocks the input
	`UGSA_ASSERT_SAME(a_in_ready, !m_tvalid, s_tready)

	// a character is never both newly placed and rejected for a full table
	`UGSA_ASSERT_SAME(a_new_or_full, m_tvalid, !(m_tdata[28] && m_tdata[29]))

	// a rejected character reports slot zero
	`UGSA_ASSERT_SAME(a_full_slot, m_tvalid && m_tdata[29], m_tdata[27:21] == 7'd0)

endmodule

bind utf8_decode_glyph_slot_assign_top ugsa_checker u_ugsa_checker (.*);

/* sim/tb_utf8_decode_glyph_slot_assign_top.sv */
// self-checking bench for the utf-8 decoder with glyph slot assignment
// streams text bytes through the block and checks every character against a local decoder or a pinned row
// depends on ugsa_pkg and utf8_decode_glyph_slot_assign_top
module tb_utf8_decode_glyph_slot_assign_top;
	import ugsa_pkg::*;

	localparam int GLYPH_SLOTS = 128;
	localparam int MAX_CHARS   = 1024;
	localparam int POS_CAP     = (MAX_CHARS - 1 < POS_FIELD_MAX) ? MAX_CHARS - 1 : POS_FIELD_MAX;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int TEXT_ROWS_N = 24;

	// one character as it leaves the block, lowest field last
	typedef struct packed {
		logic [POS_W-1:0]  char_position;
		logic              table_full;
		logic              new_glyph;
		logic [SLOT_W-1:0] glyph_slot;
		logic [CODE_W-1:0] code_point;
	} glyph_result_t;

	// directed text: byte, first of text, pinned result used in place of the decoder's
	typedef struct packed {
		logic [7:0]    text_byte;
		logic          first;
		logic          pinned;
		glyph_result_t res;
	} text_row_t;

	// pinned results read: position, full, new, slot, code point
	localparam text_row_t TEXT_ROWS [TEXT_ROWS_N] = '{
		'{8'h00, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b1, 7'd0, 21'h000000}},
		'{8'h7F, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b1, 7'd1, 21'h00007F}},
		'{8'h00, 1'b0, 1'b1, '{10'd2, 1'b0, 1'b0, 7'd0, 21'h000000}},
		// stray continuation repeats the last character
		'{8'h80, 1'b0, 1'b1, '{10'd3, 1'b0, 1'b0, 7'd0, 21'h000000}},
		'{8'hC2, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'hE0, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'hF0, 1'b0, 1'b0, '0},
		'{8'h90, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		// largest four-byte value fills all 21 bits
		'{8'hF7, 1'b0, 1'b0, '0},
		'{8'hBF, 1'b0, 1'b0, '0},
		'{8'hBF, 1'b0, 1'b0, '0},
		'{8'hBF, 1'b0, 1'b1, '{10'd7, 1'b0, 1'b1, 7'd4, 21'h1FFFFF}},
		// invalid leads repeat it
		'{8'hFF, 1'b0, 1'b1, '{10'd8, 1'b0, 1'b0, 7'd4, 21'h1FFFFF}},
		'{8'hF8, 1'b0, 1'b0, '0},
		// ascii byte taken as a continuation without a check
		'{8'hC3, 1'b0, 1'b0, '0},
		'{8'h41, 1'b0, 1'b0, '0},
		// new text drops the open sequence, stray byte then gives zero
		'{8'hE2, 1'b0, 1'b0, '0},
		'{8'hBF, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0, 7'd0, 21'h000000}},
		'{8'h41, 1'b0, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic [0:0]  s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	// local decoder state
	logic [CODE_W-1:0] seq_code;
	int                seq_left;
	logic [CODE_W-1:0] prev_code;
	int                next_pos;
	logic [CODE_W-1:0] slot_codes [GLYPH_SLOTS];
	int                slots_taken;

	glyph_result_t glyph_results_due [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_reqs     = 0;
	int hold_done     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int errors        = 0;
	int bytes_sent    = 0;
	int chars_checked = 0;
	int new_seen      = 0;
	int full_seen     = 0;
	int capped_seen   = 0;

	utf8_decode_glyph_slot_assign_top #(
		.GLYPH_SLOTS(GLYPH_SLOTS),
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // text_byte[7:0]
		.s_tuser(s_tuser),     // first_of_text[0]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// code_point[20:0], glyph_slot[27:21], new_glyph[28], table_full[29],
		// char_position[39:30]
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// decode one byte, look the character up and assign a slot
	task automatic decode_text_byte(input logic [7:0] b, input logic first,
			output bit emits, output glyph_result_t res);
		logic [CODE_W-1:0] cp;
		bit found;
		res = '0;
		emits = 1'b0;
		found = 1'b0;
		if (first) begin
			next_pos = 0;
			seq_left = 0;
			seq_code = '0;
			prev_code = '0;
		end
		if (seq_left != 0) begin
			seq_code = {seq_code[CODE_W-7:0], b[5:0]};
			seq_left--;
			if (seq_left != 0)
				return;
			cp = seq_code;
		end else if ((b & ASCII_MASK) == 8'h00) begin
			cp = CODE_W'(b);
		end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			seq_code = CODE_W'(b & ~LEAD2_MASK);
			seq_left = 1;
			return;
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			seq_code = CODE_W'(b & ~LEAD3_MASK);
			seq_left = 2;
			return;
		end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
			seq_code = CODE_W'(b & ~LEAD4_MASK);
			seq_left = 3;
			return;
		end else begin
			cp = prev_code;
		end
		prev_code = cp;
		emits = 1'b1;
		res.code_point = cp;
		// only filled slots are searched
		for (int k = 0; k < slots_taken; k++) begin
			if (!found && slot_codes[k] == cp) begin
				res.glyph_slot = SLOT_W'(k);
				found = 1'b1;
			end
		end
		if (!found) begin
			if (slots_taken < GLYPH_SLOTS) begin
				res.glyph_slot = SLOT_W'(slots_taken);
				res.new_glyph = 1'b1;
				slot_codes[slots_taken] = cp;
				slots_taken++;
			end else begin
				res.table_full = 1'b1;
			end
		end
		res.char_position = POS_W'(next_pos);
		if (next_pos < POS_CAP)
			next_pos++;
	endtask

	// offer one byte, wait for the request to be taken, log what it should produce
	task automatic send_byte(input logic [7:0] b, input logic first,
			input bit pinned, input glyph_result_t pinned_res);
		int gap;
		bit emits;
		glyph_result_t res;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
		decode_text_byte(b, first, emits, res);
		if (emits) begin
			if (pinned)
				res = pinned_res;
			glyph_results_due = {glyph_results_due, res};
		end
	endtask

	// one random character: mostly well formed, some stray, invalid or broken bytes
	task automatic send_char(input int single_pct, input int first_pct);
		int pick;
		int nbytes;
		logic [7:0] b;
		logic first;
		first = ($urandom_range(0, 99) < first_pct);
		if ($urandom_range(0, 99) < single_pct) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				b = 8'($urandom_range(0, 127));
			else if (pick < 9)
				b = 8'($urandom_range(128, 191));
			else
				b = 8'($urandom_range(248, 255));
			send_byte(b, first, 1'b0, '0);
		end else begin
			nbytes = $urandom_range(2, 4);
			if (nbytes == 2)
				b = {3'b110, 5'($urandom_range(0, 31))};
			else if (nbytes == 3)
				b = {4'b1110, 4'($urandom_range(0, 15))};
			else
				b = {5'b11110, 3'($urandom_range(0, 7))};
			send_byte(b, first, 1'b0, '0);
			for (int k = 1; k < nbytes; k++) begin
				if ($urandom_range(0, 9) == 0)
					b = 8'($urandom_range(0, 255));
				else
					b = {2'b10, 6'($urandom_range(0, 63))};
				// a new text cutting into the sequence
				first = (first_pct > 0) && ($urandom_range(0, 49) == 0);
				send_byte(b, first, 1'b0, '0);
			end
		end
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
	endtask

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_reqs != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// compare each character with the oldest one due
	always @(posedge clk) begin
		glyph_result_t got;
		glyph_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (glyph_results_due.size() == 0) begin
				$error("character with none due: code_point %0h", got.code_point);
				errors++;
			end else begin
				want = glyph_results_due.pop_front();
				chars_checked++;
				if (want.new_glyph)
					new_seen++;
				if (want.table_full)
					full_seen++;
				if (want.char_position == POS_W'(POS_CAP))
					capped_seen++;
				if (got.code_point !== want.code_point) begin
					$error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
					errors++;
				end
				if (got.glyph_slot !== want.glyph_slot) begin
					$error("glyph_slot: expected %0d, got %0d", want.glyph_slot, got.glyph_slot);
					errors++;
				end
				if (got.new_glyph !== want.new_glyph) begin
					$error("new_glyph: expected %0b, got %0b", want.new_glyph, got.new_glyph);
					errors++;
				end
				if (got.table_full !== want.table_full) begin
					$error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
					errors++;
				end
				if (got.char_position !== want.char_position) begin
					$error("char_position: expected %0d, got %0d",
						want.char_position, got.char_position);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no request moved for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int extra;
		seq_code = '0;
		seq_left = 0;
		prev_code = '0;
		next_pos = 0;
		slots_taken = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed text from an empty table
		for (int i = 0; i < TEXT_ROWS_N; i++)
			send_byte(TEXT_ROWS[i].text_byte, TEXT_ROWS[i].first, TEXT_ROWS[i].pinned,
				TEXT_ROWS[i].res);

		// both sides idling, texts restarting now and then
		set_idling(18, 18);
		while (bytes_sent < TEXT_ROWS_N + 80)
			send_char(60, 4);

		// from here on one text runs to the end
		set_idling(76, 0);
		while (bytes_sent < TEXT_ROWS_N + 160)
			send_char(60, 0);
		set_idling(0, 76);
		while (bytes_sent < TEXT_ROWS_N + 240)
			send_char(60, 0);

		// receiver holds off while bytes keep coming, so the input backs up
		set_idling(0, 0);
		hold_reqs <= hold_reqs + 1;
		for (int i = 0; i < 30; i++)
			send_char(60, 0);
		s_tvalid <= 1'b0;
		while (glyph_results_due.size() != 0)
			@(posedge clk);

		// full rate until the position saturates and stays there
		extra = 0;
		while (extra < 10) begin
			send_char(100, 0);
			if (next_pos == POS_CAP)
				extra++;
		end
		s_tvalid <= 1'b0;

		set_idling(0, 0);
		while (glyph_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d text bytes sent, %0d characters checked", bytes_sent, chars_checked);
		$display("%0d new glyphs, %0d with the table full, %0d at the position cap",
			new_seen, full_seen, capped_seen);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
